@@ rtl/mfek_pkg.sv @@
// Shared types and constants of the Edmonds-Karp maximum flow block.
// Used by mfek_ctrl, mfek_dp and max_flow_edmonds_karp. No dependencies.
`timescale 1ns / 1ps
package mfek_pkg;

  localparam int NumNodesDef = 64;
  localparam int NodeW       = 6;
  localparam int CapInW      = 16;
  localparam int CfgW        = 7;
  localparam int WordW       = 32;
  localparam int FlowOutW    = 31;
  localparam int CfgIdxW     = 1;

  localparam logic [FlowOutW-1:0] OutMax = {FlowOutW{1'b1}};
  localparam logic [WordW-1:0]    CapMax = {1'b0, {(WordW-1){1'b1}}};

  localparam logic ReqEdge = 1'b0;
  localparam logic ReqFlow = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SOURCE = 1'b0,
    CFG_SINK   = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CLR,
    CMD_LOAD,
    CMD_E_RD_FWD,
    CMD_E_RD_REV,
    CMD_E_WR,
    CMD_B_INIT,
    CMD_B_POP,
    CMD_B_CUR,
    CMD_S_SKIP,
    CMD_S_RD,
    CMD_S_CHK,
    CMD_P_RD,
    CMD_P_EDGE,
    CMD_P_CHK,
    CMD_A_W1,
    CMD_A_W2,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    logic clr_last;
    logic edge_ok;
    logic undirected;
    logic is_flow;
    logic cfg_bad;
    logic s_eq_t;
    logic q_empty;
    logic nxt_visited;
    logic nxt_last;
    logic resid_pos;
    logic nxt_is_sink;
    logic u_is_src;
  } status_t;

endpackage

@@ rtl/mfek_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mfek_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mfek_ctrl.sv @@
// Sequencer of the maximum flow block: clearing pass, edge loads, searches and path walks.
// Depends on mfek_pkg; drives the commands of mfek_dp.
`timescale 1ns / 1ps
module mfek_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  mfek_pkg::status_t st_i,
  output mfek_pkg::cmd_e    cmd_o
);
  import mfek_pkg::*;

  typedef enum logic [19:0] {
    ST_CLR   = 20'h00001,
    ST_IDLE  = 20'h00002,
    ST_DISP  = 20'h00004,
    ST_E_RD1 = 20'h00008,
    ST_E_WR1 = 20'h00010,
    ST_E_RD2 = 20'h00020,
    ST_E_WR2 = 20'h00040,
    ST_B_INI = 20'h00080,
    ST_B_POP = 20'h00100,
    ST_B_CUR = 20'h00200,
    ST_S_RD  = 20'h00400,
    ST_S_CHK = 20'h00800,
    ST_P_RD  = 20'h01000,
    ST_P_EDG = 20'h02000,
    ST_P_CHK = 20'h04000,
    ST_A_RD  = 20'h08000,
    ST_A_E1  = 20'h10000,
    ST_A_W1  = 20'h20000,
    ST_A_W2  = 20'h40000,
    ST_DONE  = 20'h80000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_e   cmd;

  always_comb begin
    state_d = state_q;
    cmd     = CMD_NOP;
    unique case (state_q)
      ST_CLR: begin
        cmd = CMD_CLR;
        if (st_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd     = CMD_LOAD;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        if (!st_i.is_flow) begin
          state_d = st_i.edge_ok ? ST_E_RD1 : ST_IDLE;
        end else begin
          state_d = (st_i.cfg_bad || st_i.s_eq_t) ? ST_DONE : ST_B_INI;
        end
      end
      ST_E_RD1: begin
        cmd     = CMD_E_RD_FWD;
        state_d = ST_E_WR1;
      end
      ST_E_WR1: begin
        cmd     = CMD_E_WR;
        state_d = st_i.undirected ? ST_E_RD2 : ST_IDLE;
      end
      ST_E_RD2: begin
        cmd     = CMD_E_RD_REV;
        state_d = ST_E_WR2;
      end
      ST_E_WR2: begin
        cmd     = CMD_E_WR;
        state_d = ST_IDLE;
      end
      ST_B_INI: begin
        cmd     = CMD_B_INIT;
        state_d = ST_B_POP;
      end
      ST_B_POP: begin
        if (st_i.q_empty) begin
          state_d = ST_DONE;
        end else begin
          cmd     = CMD_B_POP;
          state_d = ST_B_CUR;
        end
      end
      ST_B_CUR: begin
        cmd     = CMD_B_CUR;
        state_d = ST_S_RD;
      end
      ST_S_RD: begin
        if (st_i.nxt_visited) begin
          cmd = CMD_S_SKIP;
          if (st_i.nxt_last) state_d = ST_B_POP;
        end else begin
          cmd     = CMD_S_RD;
          state_d = ST_S_CHK;
        end
      end
      ST_S_CHK: begin
        cmd = CMD_S_CHK;
        priority if (st_i.resid_pos && st_i.nxt_is_sink) state_d = ST_P_RD;
        else if (st_i.nxt_last)                          state_d = ST_B_POP;
        else                                             state_d = ST_S_RD;
      end
      ST_P_RD: begin
        cmd     = CMD_P_RD;
        state_d = ST_P_EDG;
      end
      ST_P_EDG: begin
        cmd     = CMD_P_EDGE;
        state_d = ST_P_CHK;
      end
      ST_P_CHK: begin
        cmd     = CMD_P_CHK;
        state_d = st_i.u_is_src ? ST_A_RD : ST_P_RD;
      end
      ST_A_RD: begin
        cmd     = CMD_P_RD;
        state_d = ST_A_E1;
      end
      ST_A_E1: begin
        cmd     = CMD_P_EDGE;
        state_d = ST_A_W1;
      end
      ST_A_W1: begin
        cmd     = CMD_A_W1;
        state_d = ST_A_W2;
      end
      ST_A_W2: begin
        cmd     = CMD_A_W2;
        state_d = st_i.u_is_src ? ST_B_INI : ST_A_RD;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd     = CMD_OUT;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd == CMD_OUT) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

@@ rtl/mfek_dp.sv @@
// Datapath of the maximum flow block: edge store, parent and queue stores, search registers.
// Depends on mfek_pkg and mfek_ram; obeys the commands of mfek_ctrl.
`timescale 1ns / 1ps
module mfek_dp #(
  parameter int NUM_NODES = mfek_pkg::NumNodesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mfek_pkg::cmd_e                cmd_i,
  output mfek_pkg::status_t             st_o,
  input  logic                          cfg_we_i,
  input  logic [mfek_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mfek_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          req_type_i,
  input  logic [mfek_pkg::NodeW-1:0]    from_node_i,
  input  logic [mfek_pkg::NodeW-1:0]    to_node_i,
  input  logic [mfek_pkg::CapInW-1:0]   edge_capacity_i,
  input  logic                          is_directed_i,
  output logic [mfek_pkg::FlowOutW-1:0] flow_added_o,
  output logic                          not_configured_o
);
  import mfek_pkg::*;

  localparam int NW    = $clog2(NUM_NODES);
  localparam int AW    = 2 * NW;
  localparam int EDEP  = 1 << AW;
  localparam int EW    = 2 * WordW;

  // Terminal registers.
  logic [CfgW-1:0] src_q, sink_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q  <= {CfgW{1'b1}};
      sink_q <= {CfgW{1'b1}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SOURCE: src_q  <= cfg_wdata_i;
        CFG_SINK:   sink_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Latched transaction.
  logic              req_q, dir_q;
  logic [NodeW-1:0]  from_q, to_q;
  logic [CapInW-1:0] capin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) begin
      req_q   <= req_type_i;
      from_q  <= from_node_i;
      to_q    <= to_node_i;
      capin_q <= edge_capacity_i;
      dir_q   <= is_directed_i;
    end
  end

  logic [NW-1:0] s_n, t_n, a_n, b_n;
  assign s_n = NW'(src_q);
  assign t_n = NW'(sink_q);
  assign a_n = NW'(from_q);
  assign b_n = NW'(to_q);

  // Search registers.
  logic [AW-1:0]        clr_q, addr_q;
  logic [NW-1:0]        cur_q, nxt_q, v_q, u_q;
  logic [NW:0]          head_q, tail_q;
  logic [NUM_NODES-1:0] visited_q;
  logic [WordW-1:0]     cost_q;
  logic                 cost_vld_q;
  logic [FlowOutW-1:0]  total_q, flow_q;
  logic                 nc_q;

  // Stores.
  logic          e_we, e_re, p_we, p_re, q_we, q_re;
  logic [AW-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_rdata;
  logic [NW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  logic [NW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;

  mfek_ram #(.WIDTH(EW), .DEPTH(EDEP)) u_edge_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .re_i(e_re), .raddr_i(e_raddr), .rdata_o(e_rdata)
  );
  mfek_ram #(.WIDTH(NW), .DEPTH(NUM_NODES)) u_parent_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .re_i(p_re), .raddr_i(p_raddr), .rdata_o(p_rdata)
  );
  mfek_ram #(.WIDTH(NW), .DEPTH(NUM_NODES)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .re_i(q_re), .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  // Arithmetic on the edge word just read: upper half capacity, lower half flow.
  logic [WordW-1:0] rd_cap, rd_flow, cap_sat, res_w;
  logic [WordW:0]   cap_sum, res_x;
  logic             res_pos, push_ok, found;
  logic [WordW-1:0] cost_new;
  logic [WordW:0]   tot_sum;

  assign rd_cap  = e_rdata[EW-1:WordW];
  assign rd_flow = e_rdata[WordW-1:0];
  assign cap_sum = {1'b0, rd_cap} + (WordW+1)'(capin_q);
  assign cap_sat = (cap_sum > (WordW+1)'(CapMax)) ? CapMax : cap_sum[WordW-1:0];
  assign res_x   = {1'b0, rd_cap} - {rd_flow[WordW-1], rd_flow};
  assign res_pos = !res_x[WordW] && (res_x != '0);
  assign res_w   = res_x[WordW-1:0];
  assign cost_new = (!cost_vld_q || res_w < cost_q) ? res_w : cost_q;
  assign tot_sum = (WordW+1)'(total_q) + (WordW+1)'(cost_q);
  assign push_ok = tail_q < (NW+1)'(NUM_NODES);
  assign found   = (cmd_i == CMD_S_CHK) && res_pos;

  always_comb begin
    e_we = 1'b0; e_waddr = addr_q; e_wdata = '0;
    e_re = 1'b0; e_raddr = addr_q;
    p_we = 1'b0; p_waddr = nxt_q;  p_wdata = cur_q;
    p_re = 1'b0; p_raddr = v_q;
    q_we = 1'b0; q_waddr = tail_q[NW-1:0]; q_wdata = nxt_q;
    q_re = 1'b0; q_raddr = head_q[NW-1:0];
    unique case (cmd_i)
      CMD_CLR: begin
        e_we = 1'b1; e_waddr = clr_q;
      end
      CMD_E_RD_FWD: begin
        e_re = 1'b1; e_raddr = {a_n, b_n};
      end
      CMD_E_RD_REV: begin
        e_re = 1'b1; e_raddr = {b_n, a_n};
      end
      CMD_E_WR: begin
        e_we = 1'b1; e_wdata = {cap_sat, rd_flow};
      end
      CMD_B_INIT: begin
        p_we = 1'b1; p_waddr = s_n; p_wdata = s_n;
        q_we = 1'b1; q_waddr = '0;  q_wdata = s_n;
      end
      CMD_B_POP: q_re = 1'b1;
      CMD_S_RD: begin
        e_re = 1'b1; e_raddr = {cur_q, nxt_q};
      end
      CMD_S_CHK: begin
        p_we = res_pos;
        q_we = res_pos && (nxt_q != t_n) && push_ok;
      end
      CMD_P_RD: p_re = 1'b1;
      CMD_P_EDGE: begin
        e_re = 1'b1; e_raddr = {p_rdata, v_q};
      end
      CMD_A_W1: begin
        e_we = 1'b1; e_wdata = {rd_cap, rd_flow + cost_q};
        e_re = 1'b1; e_raddr = {v_q, u_q};
      end
      CMD_A_W2: begin
        e_we = 1'b1; e_wdata = {rd_cap, rd_flow - cost_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      visited_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
    end else begin
      if (cmd_i == CMD_CLR) clr_q <= clr_q + AW'(1);
      if (cmd_i == CMD_B_INIT) begin
        visited_q <= NUM_NODES'(1) << s_n;
        head_q    <= '0;
        tail_q    <= (NW+1)'(1);
      end
      if (found) visited_q[nxt_q] <= 1'b1;
      if (cmd_i == CMD_B_POP) head_q <= head_q + (NW+1)'(1);
      if (q_we && cmd_i == CMD_S_CHK) tail_q <= tail_q + (NW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_re) addr_q <= e_raddr;
    unique case (cmd_i)
      CMD_LOAD: total_q <= '0;
      CMD_B_CUR: begin
        cur_q <= q_rdata;
        nxt_q <= '0;
      end
      CMD_S_SKIP: nxt_q <= nxt_q + NW'(1);
      CMD_S_CHK: begin
        nxt_q <= nxt_q + NW'(1);
        if (res_pos && nxt_q == t_n) begin
          v_q        <= t_n;
          cost_vld_q <= 1'b0;
        end
      end
      CMD_P_EDGE: u_q <= p_rdata;
      CMD_P_CHK: begin
        cost_q     <= cost_new;
        cost_vld_q <= 1'b1;
        v_q        <= (u_q == s_n) ? t_n : u_q;
      end
      CMD_A_W2: begin
        v_q <= u_q;
        if (u_q == s_n) begin
          total_q <= (tot_sum > (WordW+1)'(OutMax)) ? OutMax : tot_sum[FlowOutW-1:0];
        end
      end
      CMD_OUT: begin
        flow_q <= st_o.cfg_bad ? '0 : total_q;
        nc_q   <= st_o.cfg_bad;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_o.clr_last    = &clr_q;
    st_o.edge_ok     = (9'(from_q) < 9'(NUM_NODES)) && (9'(to_q) < 9'(NUM_NODES));
    st_o.undirected  = !dir_q;
    st_o.is_flow     = (req_q == ReqFlow);
    st_o.cfg_bad     = src_q[CfgW-1] || sink_q[CfgW-1] ||
                       (9'(src_q) >= 9'(NUM_NODES)) || (9'(sink_q) >= 9'(NUM_NODES));
    st_o.s_eq_t      = (src_q == sink_q);
    st_o.q_empty     = (head_q == tail_q);
    st_o.nxt_visited = visited_q[nxt_q];
    st_o.nxt_last    = (nxt_q == NW'(NUM_NODES - 1));
    st_o.resid_pos   = res_pos;
    st_o.nxt_is_sink = (nxt_q == t_n);
    st_o.u_is_src    = (u_q == s_n);
  end

  assign flow_added_o     = flow_q;
  assign not_configured_o = nc_q;

endmodule

@@ rtl/max_flow_edmonds_karp.sv @@
// Top level of the Edmonds-Karp maximum flow block.
// Depends on mfek_pkg, mfek_ctrl, mfek_dp (which holds the mfek_ram stores).
//
//   Channel  Handshake                     Payload
//   in       in_valid_i / in_stall_o       req_type, from_node, to_node, edge_capacity, is_directed
//   out      out_valid_o / out_stall_i     flow_added, not_configured
//   config   cfg_we_i                      cfg_index_i, cfg_wdata_i
//
// An edge transaction is a read-modify-write of the edge RAM word, and of the reverse word too
// when undirected; in_stall_o stays high until it is through.
// A compute transaction runs searches: each starts the queue at the source, takes nodes from
// the queue and scans each one's unvisited neighbours, skipping visited ones, then walks the
// path back to find the bottleneck and walks it once more to push it.
// After reset a clearing pass writes every edge RAM word, 2^(2*ceil(log2 NUM_NODES)) of them
// (4096 at 64 nodes), during which in_stall_o stays high.
// A new transaction is taken while a result still waits for out_stall_i to fall.
`timescale 1ns / 1ps
module max_flow_edmonds_karp #(
  parameter int NUM_NODES = mfek_pkg::NumNodesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mfek_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mfek_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [mfek_pkg::NodeW-1:0]    from_node_i,
  input  logic [mfek_pkg::NodeW-1:0]    to_node_i,
  input  logic [mfek_pkg::CapInW-1:0]   edge_capacity_i,
  input  logic                          is_directed_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mfek_pkg::FlowOutW-1:0] flow_added_o,
  output logic                          not_configured_o
);
  import mfek_pkg::*;

  cmd_e    cmd;
  status_t st;

  mfek_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .st_i(st), .cmd_o(cmd)
  );

  mfek_dp #(.NUM_NODES(NUM_NODES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .st_o(st),
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .req_type_i, .from_node_i, .to_node_i, .edge_capacity_i, .is_directed_i,
    .flow_added_o, .not_configured_o
  );

  a_chk_after_rd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd == CMD_S_CHK |-> $past(cmd) == CMD_S_RD)
    else $error("neighbour check without a preceding edge read");

  a_wr_after_rd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd == CMD_E_WR |-> $past(cmd) == CMD_E_RD_FWD || $past(cmd) == CMD_E_RD_REV)
    else $error("edge write without a preceding edge read");

  a_load_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd == CMD_LOAD |-> in_valid_i && !in_stall_o)
    else $error("transaction latched without an accept");

  a_out_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd == CMD_OUT |=> out_valid_o)
    else $error("result loaded but not presented");

endmodule

@@ bench/mfek_flow_checker.sv @@
// Watches the channels of max_flow_edmonds_karp, predicts each compute result and compares it.
// Depends on mfek_pkg for widths and codes.
`timescale 1ns / 1ps
module mfek_flow_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mfek_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mfek_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          req_type_i,
  input  logic [mfek_pkg::NodeW-1:0]    from_node_i,
  input  logic [mfek_pkg::NodeW-1:0]    to_node_i,
  input  logic [mfek_pkg::CapInW-1:0]   edge_capacity_i,
  input  logic                          is_directed_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [mfek_pkg::FlowOutW-1:0] flow_added_i,
  input  logic                          not_configured_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import mfek_pkg::*;

  localparam int Nodes = NumNodesDef;
  localparam longint CapLimit = 64'h7fff_ffff;

  typedef struct packed {
    logic [FlowOutW-1:0] flow;
    logic                unset;
  } flow_res_t;

  int        cap_w [Nodes][Nodes];
  int        flow_w[Nodes][Nodes];
  int        parent[Nodes];
  int        src_node, snk_node;
  flow_res_t flow_results_q[$];

  assign pending_o = flow_results_q.size();

  function automatic longint spare(int u, int v);
    return longint'(cap_w[u][v]) - longint'(flow_w[u][v]);
  endfunction

  function automatic void add_capacity(int u, int v, longint c);
    longint x;
    x = longint'(cap_w[u][v]) + c;
    if (x > CapLimit) x = CapLimit;
    cap_w[u][v] = int'(x);
  endfunction

  // Breadth-first search in increasing node order; stops when the sink is marked.
  function automatic bit find_path(int s, int t);
    int fifo[Nodes];
    int head, tail, cur;
    head = 0;
    tail = 0;
    for (int i = 0; i < Nodes; i++) parent[i] = -1;
    parent[s] = s;
    fifo[tail++] = s;
    while (head < tail) begin
      cur = fifo[head++];
      for (int n = 0; n < Nodes; n++) begin
        if (parent[n] == -1 && spare(cur, n) > 0) begin
          parent[n] = cur;
          if (n == t) return 1'b1;
          if (tail < Nodes) fifo[tail++] = n;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic flow_res_t max_flow_step();
    flow_res_t r;
    longint    total, bott, x;
    int        v, u;
    total = 0;
    r = '0;
    if (src_node < 0 || snk_node < 0 || src_node >= Nodes || snk_node >= Nodes) begin
      r.unset = 1'b1;
      return r;
    end
    if (src_node != snk_node) begin
      while (find_path(src_node, snk_node)) begin
        bott = -1;
        for (v = snk_node; v != src_node; v = parent[v]) begin
          x = spare(parent[v], v);
          if (bott < 0 || x < bott) bott = x;
        end
        for (v = snk_node; v != src_node; v = parent[v]) begin
          u = parent[v];
          flow_w[u][v] = int'(longint'(flow_w[u][v]) + bott);
          flow_w[v][u] = int'(longint'(flow_w[v][u]) - bott);
        end
        total += bott;
      end
    end
    if (total > CapLimit) total = CapLimit;
    r.flow = total[FlowOutW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    flow_res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Nodes; i++)
        for (int j = 0; j < Nodes; j++) begin
          cap_w[i][j] = 0;
          flow_w[i][j] = 0;
        end
      src_node = -1;
      snk_node = -1;
      fail_count_o = 0;
      flow_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SOURCE) src_node = int'($signed(cfg_wdata_i));
        else snk_node = int'($signed(cfg_wdata_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (flow_results_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result flow=%0d unset=%0b", $realtime, flow_added_i,
                     not_configured_i);
        end else begin
          want = flow_results_q.pop_front();
          if (want.flow !== flow_added_i || want.unset !== not_configured_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch flow exp %0d got %0d, unset exp %0b got %0b", $realtime,
                       want.flow, flow_added_i, want.unset, not_configured_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (req_type_i == ReqEdge) begin
          add_capacity(from_node_i, to_node_i, longint'(edge_capacity_i));
          if (!is_directed_i) add_capacity(to_node_i, from_node_i, longint'(edge_capacity_i));
        end else begin
          flow_results_q.insert(flow_results_q.size(), max_flow_step());
        end
      end
    end
  end
endmodule

@@ bench/tb.sv @@
// Testbench top for max_flow_edmonds_karp: clock, reset, edge and compute stimulus, verdict.
// Depends on mfek_pkg, the block's RTL and mfek_flow_checker.
`timescale 1ns / 1ps
module tb;
  import mfek_pkg::*;

  localparam int CycleLimit = 40000000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgW-1:0]      cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 req_type_i = ReqEdge;
  logic [NodeW-1:0]     from_node_i = '0;
  logic [NodeW-1:0]     to_node_i = '0;
  logic [CapInW-1:0]    edge_capacity_i = '0;
  logic                 is_directed_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b1;
  logic [FlowOutW-1:0]  flow_added_o;
  logic                 not_configured_o;
  int                   fail_count, pending;
  int                   cycles = 0;
  bit                   no_gaps;
  logic [NodeW-1:0]     pool[8];

  always #5 clk_i = ~clk_i;

  max_flow_edmonds_karp dut (.*);

  mfek_flow_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i, .in_valid_i,
    .in_stall_i(in_stall_o), .req_type_i, .from_node_i, .to_node_i, .edge_capacity_i,
    .is_directed_i, .out_valid_i(out_valid_o), .out_stall_i, .flow_added_i(flow_added_o),
    .not_configured_i(not_configured_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The result side holds out_stall_i high for a random delay before each result, unless no_gaps is set.
  initial begin
    int n;
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send(logic req, logic [NodeW-1:0] a, logic [NodeW-1:0] b,
                      logic [CapInW-1:0] c, logic dir);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_type_i      <= req;
    from_node_i     <= a;
    to_node_i       <= b;
    edge_capacity_i <= c;
    is_directed_i   <= dir;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Edge transactions give no result, so drain waits on past the last result to cover one still in progress.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic compute();
    send(ReqFlow, 6'($urandom), 6'($urandom), 16'($urandom), 1'($urandom));
  endtask

  initial begin
    logic [CfgW-1:0] s, t;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: unset terminals, extremes of every field, equal terminals.
    compute();
    drain();
    write_reg(CFG_SOURCE, 7'd0);
    compute();
    drain();
    write_reg(CFG_SINK, 7'd63);
    send(ReqEdge, 6'd0, 6'd63, 16'hffff, 1'b1);
    send(ReqEdge, 6'd0, 6'd1, 16'd0, 1'b0);
    send(ReqEdge, 6'd0, 6'd1, 16'd7, 1'b0);
    send(ReqEdge, 6'd1, 6'd63, 16'd5, 1'b0);
    send(ReqEdge, 6'd63, 6'd63, 16'hffff, 1'b0);
    send(ReqEdge, 6'd0, 6'd2, 16'hffff, 1'b1);
    send(ReqEdge, 6'd2, 6'd63, 16'hffff, 1'b1);
    send(ReqEdge, 6'd2, 6'd63, 16'hffff, 1'b1);
    compute();
    compute();
    drain();
    write_reg(CFG_SINK, 7'd0);
    compute();
    drain();
    write_reg(CFG_SOURCE, 7'h40);
    compute();
    drain();
    write_reg(CFG_SOURCE, 7'd63);
    compute();
    drain();
    write_reg(CFG_SINK, 7'h7f);
    compute();
    drain();

    // Random phases: most edges among a small pool of nodes so paths form.
    for (int ph = 0; ph < 7; ph++) begin
      s = (ph == 0) ? 7'd63 : 7'($urandom_range(0, 63));
      t = (ph == 0) ? 7'd0 : 7'($urandom_range(0, 63));
      if (ph == 5) t = 7'h40;
      write_reg(CFG_SOURCE, s);
      write_reg(CFG_SINK, t);
      pool[0] = s[NodeW-1:0];
      pool[1] = t[NodeW-1:0];
      for (int i = 2; i < 8; i++) pool[i] = 6'($urandom);
      no_gaps = (ph == 3);
      for (int i = 0; i < 220; i++) begin
        if ($urandom_range(0, 7) == 0) compute();
        else if ($urandom_range(0, 9) == 0)
          send(ReqEdge, 6'($urandom), 6'($urandom), 16'($urandom), 1'($urandom));
        else
          send(ReqEdge, pool[$urandom_range(0, 7)], pool[$urandom_range(0, 7)],
               ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
               1'($urandom));
      end
      compute();
      no_gaps = 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
